/* design/rlfw_pkg.sv */
// Package for the recursive lock with FIFO waiters.
// Holds the request and response beat types, status codes and FSM states.
// No dependencies; imported by every module of the block.
package rlfw_pkg;

    localparam int ID_W     = 6;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 8;
    localparam int MAP_W    = 1 << ID_W;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED     = 4'd0,
        STAT_QUEUED      = 4'd1,
        STAT_DECREMENTED = 4'd2,
        STAT_FREED       = 4'd3,
        STAT_HANDOFF     = 4'd4,
        STAT_NOT_HOLDER  = 4'd5,
        STAT_ALREADY     = 4'd6,
        STAT_QUEUE_FULL  = 4'd7,
        STAT_OVERFLOW    = 4'd8
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [ID_W-1:0]     woken_thread;
        logic [COUNT_W-1:0]  count_now;
    } rsp_t;

endpackage

/* design/rlfw_qmem.sv */
// Wait-queue storage: one write port and one read port, read data registered.
// Depends on rlfw_pkg for the thread id width.
module rlfw_qmem
    import rlfw_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ID_W-1:0]   wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ID_W-1:0]   rd_data
);

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds until the next read so a stalled request keeps it.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/recursive_lock_with_fifo_waiters_top.sv */
// Recursive lock with a FIFO queue of waiting threads; top level.
// Flow: an accepted request is registered, executed in the EXEC state and its response registered;
// no new request is taken until that response is written, and EXEC waits while a full response is stalled.
// Reset (rst_n low, asynchronous): lock free, count zero, queue empty, no waiters.
// The queue memory itself is not cleared; the fill count guards every use of the head entry.
module recursive_lock_with_fifo_waiters_top
    import rlfw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_MAX   = 255
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W = $clog2(COUNT_MAX + 1);

    localparam logic [QA_W-1:0]   LAST_SLOT = QA_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(COUNT_MAX);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

    // Control state.
    fsm_t              state_reg, state_next;
    logic              held_reg, held_next;
    logic [ID_W-1:0]   owner_reg, owner_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [QA_W-1:0]   head_reg, head_next;
    logic [QA_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [MAP_W-1:0]  wait_map_reg, wait_map_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Payload registers.
    req_t              req_reg;
    rsp_t              rsp_reg, rsp_next;

    // Handshake and memory controls.
    logic              in_fire;
    logic              out_free;
    logic              exec_fire;
    logic              q_wr_en;
    logic [ID_W-1:0]   q_head_id;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    status_t           status;

    // The head entry is read on every accepted request; it is only used when
    // a final release hands the lock over, and the fill count guards it then.
    rlfw_qmem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (QA_W)
    ) u_qmem (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (tail_reg),
        .wr_data (req_reg.thread_id),
        .rd_en   (in_fire),
        .rd_addr (head_reg),
        .rd_data (q_head_id)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Sequencer outputs. A request is taken only in the idle state, so the
    // queue write of one request always lands before the head read of the next.
    always_comb
    begin
        out_free  = !rsp_valid_reg || !rsp_stall;
        req_stall = 1'b1;
        exec_fire = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                req_stall = 1'b0;
            end
            FSM_EXEC:
            begin
                exec_fire = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
        in_fire = req_valid && !req_stall;
    end

    // Lock update for the request held in req_reg.
    always_comb
    begin
        held_next     = held_reg;
        owner_next    = owner_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        wait_map_next = wait_map_reg;
        q_wr_en       = 1'b0;
        status        = STAT_GRANTED;
        rsp_next      = '0;

        if (req_reg.command == CMD_ACQUIRE)
        begin
            if (!held_reg)
            begin
                held_next  = 1'b1;
                owner_next = req_reg.thread_id;
                count_next = CNT_ONE;
                status     = STAT_GRANTED;
            end
            else if (owner_reg == req_reg.thread_id)
            begin
                if (count_reg >= CNT_MAX)
                begin
                    status = STAT_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_ONE;
                    status     = STAT_GRANTED;
                end
            end
            else if (wait_map_reg[req_reg.thread_id])
            begin
                status = STAT_ALREADY;
            end
            else if (fill_reg >= FILL_FULL)
            begin
                status = STAT_QUEUE_FULL;
            end
            else
            begin
                q_wr_en   = exec_fire;
                tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + QA_W'(1);
                fill_next = fill_reg + FILL_W'(1);
                wait_map_next[req_reg.thread_id] = 1'b1;
                status    = STAT_QUEUED;
            end
        end
        else
        begin
            if (!held_reg || owner_reg != req_reg.thread_id)
            begin
                status = STAT_NOT_HOLDER;
            end
            else if (count_reg > CNT_ONE)
            begin
                count_next = count_reg - CNT_ONE;
                status     = STAT_DECREMENTED;
            end
            else if (fill_reg != '0)
            begin
                // Final release with waiters: the oldest waiter takes the lock.
                head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + QA_W'(1);
                fill_next  = fill_reg - FILL_W'(1);
                wait_map_next[q_head_id] = 1'b0;
                owner_next = q_head_id;
                count_next = CNT_ONE;
                status     = STAT_HANDOFF;
                rsp_next.woken_valid  = 1'b1;
                rsp_next.woken_thread = q_head_id;
            end
            else
            begin
                held_next  = 1'b0;
                owner_next = '0;
                count_next = '0;
                status     = STAT_FREED;
            end
        end

        count_ext          = {{COUNT_W{1'b0}}, count_next};
        rsp_next.status    = status;
        rsp_next.count_now = count_ext[COUNT_W-1:0];
    end

    // The response register parts the two sides; it empties when taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (exec_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            wait_map_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_fire)
            begin
                held_reg     <= held_next;
                owner_reg    <= owner_next;
                count_reg    <= count_next;
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                fill_reg     <= fill_next;
                wait_map_reg <= wait_map_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req;
        end
        if (exec_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The queue never holds more waiters than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("wait queue fill exceeds depth");

    // Every queued thread has exactly one bit in the waiting map.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(wait_map_reg) == int'(fill_reg))
        else $error("waiting map out of step with queue fill");

    // A free lock has no recursion count and no waiters.
    assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> (count_reg == '0 && fill_reg == '0))
        else $error("free lock with count or waiters");

    // A held lock always carries a count of at least one.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> count_reg != '0)
        else $error("held lock with zero count");

    // An accepted request puts the sequencer into the execute state in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == FSM_EXEC)
        else $error("accepted request not processed");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the recursive lock with FIFO waiters.
// Depends on rlfw_pkg and recursive_lock_with_fifo_waiters_top from the design folder.
// A behavioral copy of the lock predicts every reply, and a monitor compares replies in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rlfw_pkg::*;

    // The block is built with its default sizes. The lock copy below uses the same ones.
    localparam int QUEUE_DEPTH  = 16;
    localparam int COUNT_LIMIT  = 255;
    localparam int RANDOM_ITEMS = 1040;
    localparam int DRAIN_CYCLES = 4000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // Behavioral copy of the lock. It is updated at the clock edge where a request
    // beat is accepted, so it always reflects every request that the block has taken.
    logic                lock_held   = 1'b0;
    logic [ID_W-1:0]     lock_owner  = '0;
    int                  lock_count  = 0;
    logic [ID_W-1:0]     waiter_fifo[$];
    logic [MAP_W-1:0]    waiter_map  = '0;

    // Replies that the lock copy has predicted and the block has not yet delivered.
    rsp_t predicted_replies[$];
    int   mismatch_count = 0;

    // When set, that side of the block never idles, which gives stretches of
    // back-to-back traffic in between the randomly gapped ones.
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    recursive_lock_with_fifo_waiters_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COUNT_MAX   (COUNT_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    // Applies one request to the lock copy and returns the reply that it must cause.
    // The order of the checks matters: the holder test comes before the waiter test,
    // and a thread that already waits is reported as such even when the queue is full.
    function automatic rsp_t apply_lock_request(input req_t item);
        rsp_t            reply;
        logic [ID_W-1:0] heir;
        reply = '0;
        if (item.command == CMD_ACQUIRE)
        begin
            if (!lock_held)
            begin
                lock_held    = 1'b1;
                lock_owner   = item.thread_id;
                lock_count   = 1;
                reply.status = STAT_GRANTED;
            end
            else if (lock_owner == item.thread_id)
            begin
                if (lock_count >= COUNT_LIMIT)
                    reply.status = STAT_OVERFLOW;
                else
                begin
                    lock_count++;
                    reply.status = STAT_GRANTED;
                end
            end
            else if (waiter_map[item.thread_id])
                reply.status = STAT_ALREADY;
            else if (waiter_fifo.size() >= QUEUE_DEPTH)
                reply.status = STAT_QUEUE_FULL;
            else
            begin
                waiter_fifo.push_back(item.thread_id);
                waiter_map[item.thread_id] = 1'b1;
                reply.status = STAT_QUEUED;
            end
        end
        else
        begin
            if (!lock_held || lock_owner != item.thread_id)
                reply.status = STAT_NOT_HOLDER;
            else if (lock_count > 1)
            begin
                lock_count--;
                reply.status = STAT_DECREMENTED;
            end
            else if (waiter_fifo.size() != 0)
            begin
                // Final release with waiters: the oldest waiter gets the lock directly.
                heir                 = waiter_fifo.pop_front();
                waiter_map[heir]     = 1'b0;
                lock_owner           = heir;
                lock_count           = 1;
                reply.woken_valid    = 1'b1;
                reply.woken_thread   = heir;
                reply.status         = STAT_HANDOFF;
            end
            else
            begin
                lock_held    = 1'b0;
                lock_owner   = '0;
                lock_count   = 0;
                reply.status = STAT_FREED;
            end
        end
        reply.count_now = lock_count[COUNT_W-1:0];
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Sends one request beat. It is entered and left at a falling edge. Valid stays
    // high between beats when there is no gap, and the payload only changes after
    // the beat has been accepted.
    task automatic send_request(input logic cmd, input logic [ID_W-1:0] tid);
        int   gap;
        req_t item;
        item.command   = cmd;
        item.thread_id = tid;
        gap = sender_steady ? 0 : idle_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        predicted_replies.push_back(apply_lock_request(item));
        @(negedge clk);
    endtask

    // Holds the sender off until every predicted reply has arrived, or the cycle
    // budget runs out. It always lets at least one clock pass.
    task automatic wait_for_replies(input int budget);
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (predicted_replies.size() != 0 && waited < budget);
    endtask

    // Releases on behalf of whoever holds the lock until it is free. This walks the
    // whole recursion count and hands the lock down the wait queue on the way.
    task automatic release_until_free();
        while (lock_held)
            send_request(CMD_RELEASE, lock_owner);
    endtask

    // Acquire and release on a free lock, with the lowest and highest thread ids,
    // and releases that arrive while the lock is free.
    task automatic test_free_lock_paths();
        send_request(CMD_ACQUIRE, 6'd0);
        send_request(CMD_RELEASE, 6'd0);
        send_request(CMD_ACQUIRE, 6'd63);
        send_request(CMD_RELEASE, 6'd63);
        send_request(CMD_RELEASE, 6'd63);
        send_request(CMD_RELEASE, 6'd21);
    endtask

    // Recursion, queuing, a repeat waiter, a release by a thread that does not hold
    // the lock, and handoff in arrival order down to a free lock.
    task automatic test_handoff_order();
        send_request(CMD_ACQUIRE, 6'd10);
        send_request(CMD_ACQUIRE, 6'd10);
        send_request(CMD_ACQUIRE, 6'd42);
        send_request(CMD_ACQUIRE, 6'd42);
        send_request(CMD_ACQUIRE, 6'd63);
        send_request(CMD_RELEASE, 6'd42);
        send_request(CMD_ACQUIRE, 6'd0);
        send_request(CMD_RELEASE, 6'd10);
        send_request(CMD_RELEASE, 6'd10);
        send_request(CMD_RELEASE, 6'd63);
        release_until_free();
    endtask

    // Fills the wait queue, then tries a new thread, a thread that already waits and
    // the holder itself while the queue is full.
    task automatic test_queue_full();
        send_request(CMD_ACQUIRE, 6'd1);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(CMD_ACQUIRE, 6'(32 + i));
        send_request(CMD_ACQUIRE, 6'd60);
        send_request(CMD_ACQUIRE, 6'd40);
        send_request(CMD_ACQUIRE, 6'd1);
        release_until_free();
    endtask

    // Drives the recursion count to its ceiling and one acquire past it, then lets
    // a waiter take over once the count has been walked back down.
    task automatic test_recursion_limit();
        repeat (COUNT_LIMIT)
            send_request(CMD_ACQUIRE, 6'd7);
        send_request(CMD_ACQUIRE, 6'd7);
        send_request(CMD_ACQUIRE, 6'd50);
        send_request(CMD_RELEASE, 6'd50);
        release_until_free();
    endtask

    // One random request, shaped by the lock copy so that most traffic is meaningful:
    // releases by the holder, recursive acquires, acquires by waiting threads, stray
    // releases and acquires by any thread id.
    task automatic send_random_request(input int release_weight);
        int roll;
        roll = $urandom_range(0, 99);
        if (lock_held && roll < release_weight)
            send_request(CMD_RELEASE, lock_owner);
        else if (lock_held && roll < release_weight + 12)
            send_request(CMD_ACQUIRE, lock_owner);
        else if (waiter_fifo.size() != 0 && roll < release_weight + 22)
            send_request(CMD_ACQUIRE, waiter_fifo[$urandom_range(0, waiter_fifo.size() - 1)]);
        else if (roll >= 92)
            send_request(CMD_RELEASE, 6'($urandom_range(0, 63)));
        else
            send_request(CMD_ACQUIRE, 6'($urandom_range(0, 63)));
    endtask

    // Random traffic in eight phases. Even phases lean toward acquires so the queue
    // fills up, odd phases lean toward releases so it drains through handoffs. Some
    // phases switch idling off on one or both sides, and one phase ends with the
    // sender holding back until every reply is in.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++)
        begin
            sender_steady   = (phase == 2 || phase == 5);
            receiver_steady = (phase == 3 || phase == 5);
            repeat (RANDOM_ITEMS / 8)
                send_random_request((phase % 2 == 1) ? 50 : 25);
            if (phase == 3)
                wait_for_replies(DRAIN_CYCLES);
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Receiver stall pattern, driven at the falling edge. The stall lengths follow
    // the same mostly-short distribution as the sender gaps.
    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            rsp_stall <= 1'b0;
            repeat (idle_length() + $urandom_range(1, 4)) @(negedge clk);
            if (!receiver_steady)
            begin
                rsp_stall <= 1'b1;
                repeat (idle_length() + 1) @(negedge clk);
            end
        end
    end

    // Reply monitor: each accepted reply beat is compared with the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_replies.size() == 0)
                report_mismatch("reply beat with no request pending", rsp.status, -1);
            else
            begin
                want = predicted_replies.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.woken_valid !== want.woken_valid)
                    report_mismatch("woken_valid", rsp.woken_valid, want.woken_valid);
                if (rsp.woken_thread !== want.woken_thread)
                    report_mismatch("woken_thread", rsp.woken_thread, want.woken_thread);
                if (rsp.count_now !== want.count_now)
                    report_mismatch("count_now", rsp.count_now, want.count_now);
            end
        end
    end

    // Main sequence: reset, directed cases, random traffic, then wait for the last
    // replies and keep the clock running to catch any stray beat.
    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_free_lock_paths();
        test_handoff_order();
        test_queue_full();
        test_recursion_limit();
        test_random_traffic();

        wait_for_replies(DRAIN_CYCLES);
        repeat (4) @(negedge clk);
        if (predicted_replies.size() != 0)
            report_mismatch("replies never delivered", 0, predicted_replies.size());

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
design/rlfw_pkg.sv
design/rlfw_qmem.sv
design/recursive_lock_with_fifo_waiters_top.sv
sim/testbench.sv
